// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/odo_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the odometry block.
// No dependencies.
`timescale 1ns / 1ps
package odo_pkg;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ANGLE_TABLE_LEN = 30;
    localparam int ITER_COUNT = (TRIG_ITERATIONS < ANGLE_TABLE_LEN) ?
                                TRIG_ITERATIONS : ANGLE_TABLE_LEN;
    localparam int ITER_W = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_COUNT - 1);
    localparam int CORDIC_W = 34;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

    typedef enum logic [2:0] {
        CFG_RIGHT_MM    = 3'd0,
        CFG_LEFT_MM     = 3'd1,
        CFG_TURN        = 3'd2,
        CFG_INTERVAL    = 3'd3,
        CFG_DIST_LIMIT  = 3'd4,
        CFG_ANGLE_LIMIT = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORDIC, ST_MUL_R, ST_MUL_L, ST_SUMDIFF,
        ST_MX_LO, ST_MX_HI, ST_MY_LO, ST_MY_HI, ST_MT_LO, ST_MT_HI,
        ST_UPDATE, ST_CHECK, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_R, MUL_L, MUL_X_LO, MUL_X_HI, MUL_Y_LO, MUL_Y_HI,
        MUL_T_LO, MUL_T_HI
    } t_mul_op;

    typedef struct packed {
        logic               accept;
        logic               cordic_step;
        logic [ITER_W-1:0]  cordic_idx;
        t_mul_op            mul_op;
        logic               sum_diff;
        logic               update;
        logic               check;
        logic               publish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [31:0] atan_units(input logic [ITER_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/odo_ctrl.sv =====
// Sequencer for the odometry block: steps the datapath through one item.
// Depends on odo_pkg.
`timescale 1ns / 1ps
module odo_ctrl import odo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.cordic_idx = r_iter;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // take nothing while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_iter = '0;
                    n_state = i_s_tuser ? ST_DONE : ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) n_state = ST_MUL_R;
            end
            ST_MUL_R: begin
                o_cmd.mul_op = MUL_R;
                n_state = ST_MUL_L;
            end
            ST_MUL_L: begin
                o_cmd.mul_op = MUL_L;
                n_state = ST_SUMDIFF;
            end
            ST_SUMDIFF: begin
                o_cmd.sum_diff = 1'b1;
                n_state = ST_MX_LO;
            end
            ST_MX_LO: begin
                o_cmd.mul_op = MUL_X_LO;
                n_state = ST_MX_HI;
            end
            ST_MX_HI: begin
                o_cmd.mul_op = MUL_X_HI;
                n_state = ST_MY_LO;
            end
            ST_MY_LO: begin
                o_cmd.mul_op = MUL_Y_LO;
                n_state = ST_MY_HI;
            end
            ST_MY_HI: begin
                o_cmd.mul_op = MUL_Y_HI;
                n_state = ST_MT_LO;
            end
            ST_MT_LO: begin
                o_cmd.mul_op = MUL_T_LO;
                n_state = ST_MT_HI;
            end
            ST_MT_HI: begin
                o_cmd.mul_op = MUL_T_HI;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/odo_dp.sv =====
// Datapath of the odometry block: pose state, CORDIC, shared multiplier,
// movement check and output register. Depends on odo_pkg.
`timescale 1ns / 1ps
module odo_dp import odo_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tuser,
    output logic [95:0]  o_m_tdata,
    output logic         o_m_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  t_cmd         i_cmd,
    output t_status      o_status
);
    logic [15:0] r_right_mm, r_left_mm, r_interval;
    logic [31:0] r_turn;
    logic [30:0] r_dist_limit, r_angle_limit;

    logic [15:0] r_prev_r, r_prev_l, r_countdown;
    logic [31:0] r_x, r_y, r_h, r_snap_x, r_snap_y, r_snap_h;
    logic        r_still;

    logic signed [16:0] r_dr, r_dl;
    logic signed [32:0] r_mmr, r_mml;
    logic signed [33:0] r_sum, r_diff;
    logic signed [CORDIC_W-1:0] r_cx, r_cy, r_cz;
    logic        r_flip;
    logic signed [67:0] r_px, r_py;
    logic [63:0] r_pt;
    logic        r_valid;
    logic [95:0] r_out_data;
    logic        r_out_still;

    logic [15:0] s_rdelta, s_ldelta;
    logic signed [33:0] s_z0;
    logic signed [CORDIC_W-1:0] s_xs, s_ys, s_atan;
    logic signed [32:0] s_cos, s_sin, s_b;
    logic signed [17:0] s_a;
    logic signed [50:0] s_p;
    logic signed [67:0] s_p68, s_rx, s_ry;
    logic signed [36:0] s_dx, s_dy;
    logic signed [37:0] s_xn, s_yn;
    logic [63:0] s_rt;
    logic signed [32:0] s_cdx, s_cdy, s_adx, s_ady;
    logic [31:0] s_dh;
    logic signed [32:0] s_adh;
    logic        s_still;

    function automatic logic [31:0] sat38(input logic signed [37:0] v);
        if (v > 38'sd2147483647) return 32'h7FFFFFFF;
        else if (v < -38'sd2147483648) return 32'h80000000;
        else return v[31:0];
    endfunction

    always_comb begin
        s_rdelta = i_s_tdata[15:0] - r_prev_r;
        s_ldelta = i_s_tdata[31:16] - r_prev_l;
        s_z0 = 34'(signed'(r_h));
        s_xs = r_cx >>> i_cmd.cordic_idx;
        s_ys = r_cy >>> i_cmd.cordic_idx;
        s_atan = $signed({2'b00, atan_units(i_cmd.cordic_idx)});
        s_cos = r_flip ? 33'(-r_cx) : r_cx[32:0];
        s_sin = r_flip ? 33'(-r_cy) : r_cy[32:0];
        s_a = '0;
        s_b = '0;
        case (i_cmd.mul_op)
            MUL_R: begin
                s_a = 18'(r_dr);
                s_b = $signed({17'd0, r_right_mm});
            end
            MUL_L: begin
                s_a = 18'(r_dl);
                s_b = $signed({17'd0, r_left_mm});
            end
            MUL_X_LO: begin
                s_a = $signed({1'b0, r_sum[16:0]});
                s_b = s_cos;
            end
            MUL_X_HI: begin
                s_a = 18'(signed'(r_sum[33:17]));
                s_b = s_cos;
            end
            MUL_Y_LO: begin
                s_a = $signed({1'b0, r_sum[16:0]});
                s_b = s_sin;
            end
            MUL_Y_HI: begin
                s_a = 18'(signed'(r_sum[33:17]));
                s_b = s_sin;
            end
            MUL_T_LO: begin
                s_a = $signed({1'b0, r_diff[16:0]});
                s_b = $signed({1'b0, r_turn});
            end
            MUL_T_HI: begin
                s_a = 18'(signed'(r_diff[33:17]));
                s_b = $signed({1'b0, r_turn});
            end
            default: begin
                s_a = '0;
                s_b = '0;
            end
        endcase
        s_p = s_a * s_b;
        s_p68 = 68'(s_p);
        // round half up, then floor shift
        s_rx = r_px + 68'sd1073741824;
        s_ry = r_py + 68'sd1073741824;
        s_dx = s_rx[67:31];
        s_dy = s_ry[67:31];
        s_xn = 38'(signed'(r_x)) + 38'(s_dx);
        s_yn = 38'(signed'(r_y)) + 38'(s_dy);
        s_rt = r_pt + 64'h0000_0000_8000_0000;
        s_cdx = 33'(signed'(r_x)) - 33'(signed'(r_snap_x));
        s_cdy = 33'(signed'(r_y)) - 33'(signed'(r_snap_y));
        s_adx = (s_cdx < 0) ? -s_cdx : s_cdx;
        s_ady = (s_cdy < 0) ? -s_cdy : s_cdy;
        s_dh = r_h - r_snap_h;
        s_adh = s_dh[31] ? -33'(signed'(s_dh)) : 33'(signed'(s_dh));
        s_still = (s_adx < $signed({2'b00, r_dist_limit})) &&
                  (s_ady < $signed({2'b00, r_dist_limit})) &&
                  (s_adh < $signed({2'b00, r_angle_limit}));
        o_status.out_free = !r_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_mm <= '0;
            r_left_mm <= '0;
            r_turn <= '0;
            r_interval <= 16'd1;
            r_dist_limit <= '0;
            r_angle_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RIGHT_MM:    r_right_mm <= i_cfg_data[15:0];
                CFG_LEFT_MM:     r_left_mm <= i_cfg_data[15:0];
                CFG_TURN:        r_turn <= i_cfg_data;
                CFG_INTERVAL:    r_interval <= i_cfg_data[15:0];
                CFG_DIST_LIMIT:  r_dist_limit <= i_cfg_data[30:0];
                CFG_ANGLE_LIMIT: r_angle_limit <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_r <= '0;
            r_prev_l <= '0;
            r_x <= '0;
            r_y <= '0;
            r_h <= '0;
            r_countdown <= '0;
            r_snap_x <= '0;
            r_snap_y <= '0;
            r_snap_h <= '0;
            r_still <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_s_tuser) begin
                    r_x <= i_s_tdata[63:32];
                    r_y <= i_s_tdata[95:64];
                    r_h <= i_s_tdata[127:96];
                end else begin
                    r_prev_r <= i_s_tdata[15:0];
                    r_prev_l <= i_s_tdata[31:16];
                end
            end
            if (i_cmd.update) begin
                r_x <= sat38(s_xn);
                r_y <= sat38(s_yn);
                r_h <= r_h + s_rt[63:32];
            end
            if (i_cmd.check) begin
                if (r_countdown > 16'd1) begin
                    r_countdown <= r_countdown - 16'd1;
                end else begin
                    r_countdown <= r_interval;
                    r_still <= s_still;
                    r_snap_x <= r_x;
                    r_snap_y <= r_y;
                    r_snap_h <= r_h;
                end
            end
            if (i_cmd.publish) r_valid <= 1'b1;
            else if (i_m_tready) r_valid <= 1'b0;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dr <= 17'(signed'(s_rdelta));
            r_dl <= -17'(signed'(s_ldelta));
            r_cx <= $signed({2'b00, CORDIC_GAIN_Q30});
            r_cy <= '0;
            // fold headings beyond a quarter turn back by a half turn
            if (s_z0 > QUARTER_TURN) begin
                r_cz <= s_z0 - HALF_TURN;
                r_flip <= 1'b1;
            end else if (s_z0 < -QUARTER_TURN) begin
                r_cz <= s_z0 + HALF_TURN;
                r_flip <= 1'b1;
            end else begin
                r_cz <= s_z0;
                r_flip <= 1'b0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - s_ys;
                r_cy <= r_cy + s_xs;
                r_cz <= r_cz - s_atan;
            end else begin
                r_cx <= r_cx + s_ys;
                r_cy <= r_cy - s_xs;
                r_cz <= r_cz + s_atan;
            end
        end
        if (i_cmd.sum_diff) begin
            r_sum <= 34'(r_mmr) + 34'(r_mml);
            r_diff <= 34'(r_mmr) - 34'(r_mml);
        end
        case (i_cmd.mul_op)
            MUL_R:    r_mmr <= s_p[32:0];
            MUL_L:    r_mml <= s_p[32:0];
            MUL_X_LO: r_px <= s_p68;
            MUL_X_HI: r_px <= r_px + (s_p68 <<< 17);
            MUL_Y_LO: r_py <= s_p68;
            MUL_Y_HI: r_py <= r_py + (s_p68 <<< 17);
            MUL_T_LO: r_pt <= s_p68[63:0];
            MUL_T_HI: r_pt <= r_pt + (s_p68[63:0] << 17);
            default: ;
        endcase
        if (i_cmd.publish) begin
            r_out_data <= {r_h, r_y, r_x};
            r_out_still <= r_still;
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_still;
    assign o_m_tvalid = r_valid;
endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Sample item: after its transfer the sequencer runs the CORDIC steps (16 at
// the default TRIG_ITERATIONS), then MUL_R, MUL_L, SUMDIFF, the MX, MY and MT
// multiplies (low then high half each), UPDATE, CHECK and DONE; no new transfer
// is taken until the result is published. Load item: goes straight to DONE.
// A full output register holds the finish state until it drains. Synchronous
// active-low reset clears pose, counters and configuration (still_interval to 1).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module differential_drive_odometry import odo_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // right_count[15:0], left_count[31:16], load_x[63:32], load_y[95:64],
    // load_heading[127:96]
    input  logic [127:0] i_s_tdata,
    // kind
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x[31:0], pos_y[63:32], heading[95:64]
    output logic [95:0]  o_m_tdata,
    // still
    output logic         o_m_tuser
);
    t_cmd       s_cmd;
    t_status    s_status;
    logic [4:0] s_strobes;

    odo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    odo_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cmd      (s_cmd),
        .o_status   (s_status)
    );

    assign s_strobes = {s_cmd.cordic_step, s_cmd.update, s_cmd.check, s_cmd.publish,
                        s_cmd.accept};

    `ASSERT_NEVER(a_one_strobe, i_clk, i_rst_n, $countones(s_strobes) > 1)
    `ASSERT_IMPL(a_busy_after_sample, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !i_s_tuser, !o_s_tready)
    `ASSERT_IMPL(a_publish_valid, i_clk, i_rst_n, s_cmd.publish, o_m_tvalid)
endmodule
